/* design/iepfb_pkg.sv */
package iepfb_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SOURCE_MAC     = 3'd0,
    REG_DEST_MAC       = 3'd1,
    REG_OWN_IP_ADDR    = 3'd2,
    REG_TARGET_ADDRESS = 3'd3,
    REG_PAYLOAD_BYTES  = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned PlenW    = 7;
  localparam int unsigned WordIdxW = 6;

  localparam logic [PlenW-1:0] MAX_PAYLOAD_BYTES = 7'd86;
  localparam logic [PlenW-1:0] PLEN_RESET        = 7'd20;

  // frame word positions
  localparam logic [WordIdxW-1:0] W_ETH_TYPE      = 6'd6;
  localparam logic [WordIdxW-1:0] W_IP_FIRST      = 6'd7;
  localparam logic [WordIdxW-1:0] W_IP_LEN        = 6'd8;
  localparam logic [WordIdxW-1:0] W_IP_ID         = 6'd9;
  localparam logic [WordIdxW-1:0] W_IP_FLAGS      = 6'd10;
  localparam logic [WordIdxW-1:0] W_IP_TTL        = 6'd11;
  localparam logic [WordIdxW-1:0] W_IP_CSUM       = 6'd12;
  localparam logic [WordIdxW-1:0] W_IP_LAST       = 6'd16;
  localparam logic [WordIdxW-1:0] W_ICMP_FIRST    = 6'd17;
  localparam logic [WordIdxW-1:0] W_ICMP_CSUM     = 6'd18;
  localparam logic [WordIdxW-1:0] W_ICMP_ID       = 6'd19;
  localparam logic [WordIdxW-1:0] W_ICMP_SEQ      = 6'd20;
  localparam logic [WordIdxW-1:0] W_PAYLOAD_FIRST = 6'd21;

  // header constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] IP_VER_TOS     = 16'h4500;
  localparam logic [15:0] IP_HDR_ICMP    = 16'd28;
  localparam logic [15:0] IP_ID          = 16'habcd;
  localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
  localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0800;
  localparam logic [15:0] ICMP_ID        = 16'h1234;
  localparam logic [15:0] ICMP_SEQ       = 16'h0001;

  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;

  typedef struct packed {
    logic [47:0]      source_mac;
    logic [47:0]      dest_mac;
    logic [31:0]      own_ip_addr;
    logic [31:0]      target_address;
    logic [PlenW-1:0] payload_bytes;
  } cfg_t;

  // checksum accumulator control
  typedef struct packed {
    logic clr;
    logic add;
  } csum_ctl_t;

  // one generated frame word
  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  cnt;
    logic        last;
  } gen_word_t;

endpackage

/* design/iepfb_if.sv */
interface iepfb_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] probe_ttl;

  modport source (output valid, output probe_ttl, input ready);
  modport sink (input valid, input probe_ttl, output ready);
endinterface

interface iepfb_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_word;
  logic [1:0]  byte_count;
  logic        last_word;

  modport source (output valid, output frame_word, output byte_count, output last_word,
                  input ready);
  modport sink (input valid, input frame_word, input byte_count, input last_word,
                output ready);
endinterface

/* design/iepfb_csum_unit.sv */
module iepfb_csum_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iepfb_pkg::csum_ctl_t ctl_i,
  input  logic [15:0]          word_i,
  output logic [15:0]          csum_o
);
  import iepfb_pkg::*;

  logic [15:0] acc_q, acc_d;
  logic [16:0] sum;

  // ones'-complement add with end-around carry
  always_comb begin
    sum   = {1'b0, acc_q} + {1'b0, word_i};
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.add) begin
      acc_d = sum[15:0] + {15'd0, sum[16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // complemented running sum
  assign csum_o = ~acc_q;

endmodule

/* design/iepfb_word_gen.sv */
module iepfb_word_gen (
  input  iepfb_pkg::cfg_t                         cfg_i,
  input  logic [iepfb_pkg::PlenW-1:0]             plen_i,
  input  logic [7:0]                              ttl_i,
  input  logic [15:0]                             ip_csum_i,
  input  logic [15:0]                             icmp_csum_i,
  input  logic [iepfb_pkg::WordIdxW-1:0]          idx_i,
  output iepfb_pkg::gen_word_t                    gen_o
);
  import iepfb_pkg::*;

  logic [WordIdxW-1:0] k;
  logic [PlenW-1:0]    hi_byte;
  logic                lo_ok;
  logic [PlenW:0]      half;
  logic [WordIdxW-1:0] last_idx;

  // payload byte pair and final word position
  always_comb begin
    k        = idx_i - W_PAYLOAD_FIRST;
    hi_byte  = {k, 1'b0};
    lo_ok    = ({1'b0, hi_byte} + 8'd1) < {1'b0, plen_i};
    half     = ({1'b0, plen_i} + 8'd1) >> 1;
    last_idx = W_ICMP_SEQ + half[WordIdxW-1:0];
  end

  // word decoder
  always_comb begin
    gen_o.last = (idx_i == last_idx);
    gen_o.cnt  = (gen_o.last && plen_i[0]) ? CNT_ONE : CNT_TWO;
    unique case (idx_i)
      6'd0:         gen_o.word = cfg_i.dest_mac[47:32];
      6'd1:         gen_o.word = cfg_i.dest_mac[31:16];
      6'd2:         gen_o.word = cfg_i.dest_mac[15:0];
      6'd3:         gen_o.word = cfg_i.source_mac[47:32];
      6'd4:         gen_o.word = cfg_i.source_mac[31:16];
      6'd5:         gen_o.word = cfg_i.source_mac[15:0];
      W_ETH_TYPE:   gen_o.word = ETHERTYPE_IPV4;
      W_IP_FIRST:   gen_o.word = IP_VER_TOS;
      W_IP_LEN:     gen_o.word = IP_HDR_ICMP + {9'd0, plen_i};
      W_IP_ID:      gen_o.word = IP_ID;
      W_IP_FLAGS:   gen_o.word = IP_FLAGS_DF;
      W_IP_TTL:     gen_o.word = {ttl_i, IP_PROTO_ICMP};
      W_IP_CSUM:    gen_o.word = ip_csum_i;
      6'd13:        gen_o.word = cfg_i.own_ip_addr[31:16];
      6'd14:        gen_o.word = cfg_i.own_ip_addr[15:0];
      6'd15:        gen_o.word = cfg_i.target_address[31:16];
      W_IP_LAST:    gen_o.word = cfg_i.target_address[15:0];
      W_ICMP_FIRST: gen_o.word = ICMP_ECHO_REQ;
      W_ICMP_CSUM:  gen_o.word = icmp_csum_i;
      W_ICMP_ID:    gen_o.word = ICMP_ID;
      W_ICMP_SEQ:   gen_o.word = ICMP_SEQ;
      default:      gen_o.word = {1'b0, hi_byte, lo_ok ? {1'b0, hi_byte | 7'd1} : 8'd0};
    endcase
  end

endmodule

/* design/icmp_echo_probe_frame_builder.sv */
// channel | dir | payload                               | accepted when
// req_i   | in  | probe_ttl                             | valid && ready
// word_o  | out | frame_word, byte_count, last_word     | valid && ready
// cfg     | in  | cfg_idx_i, cfg_wdata_i                | cfg_we_i
//
// one request builds a frame of N = 21 + ceil(payload/2) words
// (up to 64); the single ones'-complement adder sums the ip header, then the
// icmp part, then the frame is streamed one word a cycle while word_o is not stalled
// req_i.ready is high only while idle; the last word may still wait in the output register
// reset clears control and config (payload_bytes to 20); a stall on word_o holds the sequencer
module icmp_echo_probe_frame_builder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [iepfb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [iepfb_pkg::CfgDataW-1:0]   cfg_wdata_i,
  iepfb_req_if.sink                        req_i,
  iepfb_word_if.source                     word_o
);
  import iepfb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IP_SUM,
    ST_IP_FIN,
    ST_ICMP_SUM,
    ST_ICMP_FIN,
    ST_EMIT
  } state_e;

  cfg_t                cfg_q;
  state_e              state_q, state_d;
  logic [WordIdxW-1:0] idx_q, idx_d;
  logic [7:0]          ttl_q, ttl_d;
  logic [PlenW-1:0]    plen_q, plen_d;
  logic [15:0]         ip_csum_q, ip_csum_d;
  logic [15:0]         icmp_csum_q, icmp_csum_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_word_q, out_word_d;
  logic [1:0]          out_cnt_q, out_cnt_d;
  logic                out_last_q, out_last_d;

  csum_ctl_t   csum_ctl;
  logic [15:0] csum;
  gen_word_t   gen;
  logic        req_fire;
  logic        out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{payload_bytes: PLEN_RESET, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE_MAC:     cfg_q.source_mac     <= cfg_wdata_i;
        REG_DEST_MAC:       cfg_q.dest_mac       <= cfg_wdata_i;
        REG_OWN_IP_ADDR:    cfg_q.own_ip_addr    <= cfg_wdata_i[31:0];
        REG_TARGET_ADDRESS: cfg_q.target_address <= cfg_wdata_i[31:0];
        REG_PAYLOAD_BYTES:  cfg_q.payload_bytes  <= cfg_wdata_i[PlenW-1:0];
        default: ;
      endcase
    end
  end

  iepfb_word_gen u_word_gen (
    .cfg_i       (cfg_q),
    .plen_i      (plen_q),
    .ttl_i       (ttl_q),
    .ip_csum_i   (ip_csum_q),
    .icmp_csum_i (icmp_csum_q),
    .idx_i       (idx_q),
    .gen_o       (gen)
  );

  iepfb_csum_unit u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (csum_ctl),
    .word_i (gen.word),
    .csum_o (csum)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || word_o.ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ttl_d       = ttl_q;
    plen_d      = plen_q;
    ip_csum_d   = ip_csum_q;
    icmp_csum_d = icmp_csum_q;
    out_valid_d = out_valid_q && !word_o.ready;
    out_word_d  = out_word_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;
    csum_ctl    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          ttl_d        = req_i.probe_ttl;
          plen_d       = (cfg_q.payload_bytes > MAX_PAYLOAD_BYTES) ?
                         MAX_PAYLOAD_BYTES : cfg_q.payload_bytes;
          ip_csum_d    = '0;
          icmp_csum_d  = '0;
          idx_d        = W_IP_FIRST;
          csum_ctl.clr = 1'b1;
          state_d      = ST_IP_SUM;
        end
      end
      ST_IP_SUM: begin
        csum_ctl.add = 1'b1;
        if (idx_q == W_IP_LAST) begin
          state_d = ST_IP_FIN;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_IP_FIN: begin
        ip_csum_d    = csum;
        csum_ctl.clr = 1'b1;
        idx_d        = W_ICMP_FIRST;
        state_d      = ST_ICMP_SUM;
      end
      ST_ICMP_SUM: begin
        csum_ctl.add = 1'b1;
        if (gen.last) begin
          state_d = ST_ICMP_FIN;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      ST_ICMP_FIN: begin
        icmp_csum_d = csum;
        idx_d       = '0;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = gen.word;
          out_cnt_d   = gen.cnt;
          out_last_d  = gen.last;
          if (gen.last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      ttl_q       <= '0;
      plen_q      <= '0;
      ip_csum_q   <= '0;
      icmp_csum_q <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ttl_q       <= ttl_d;
      plen_q      <= plen_d;
      ip_csum_q   <= ip_csum_d;
      icmp_csum_q <= icmp_csum_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      out_cnt_q   <= out_cnt_d;
      out_last_q  <= out_last_d;
    end
  end

  assign word_o.valid      = out_valid_q;
  assign word_o.frame_word = out_word_q;
  assign word_o.byte_count = out_cnt_q;
  assign word_o.last_word  = out_last_q;

  // a request always starts the ip header sum
  a_req_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == ST_IP_SUM)
    else $error("request did not start checksum pass");

  // new output words only come out of the emit phase
  a_word_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("output word outside emit phase");

  // a short word is always the final one
  a_short_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_cnt_q == CNT_ONE |-> out_last_q)
    else $error("padded word not marked last");

  // emit ends only after handing out the final word
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_EMIT) && state_q == ST_IDLE |-> out_valid_q && out_last_q)
    else $error("frame ended without final word");

endmodule
